### hdl/e2q_pkg.sv
// Package for the Euler-to-quaternion converter: payload types, CORDIC constants,
// arctangent table. No dependencies.
package e2q_pkg;

   localparam int ANGLE_W      = 16;
   localparam int QUAT_W       = 16;
   localparam int CORDIC_W     = 34;
   localparam int TRIG_W       = 17;
   localparam int STAGES_DEF   = 16;
   localparam int STAGES_MAX   = 24;
   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
   localparam logic signed [CORDIC_W-1:0] INV_GAIN = 34'sd652032874;
   localparam logic signed [QUAT_W-1:0] QUAT_LIMIT = 16'sd16384;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } trig_type;

   function automatic logic signed [CORDIC_W-1:0] atan_entry(input int i);
      logic signed [CORDIC_W-1:0] v;
      case (i)
         0: v = 34'sd843314857;
         1: v = 34'sd497837829;
         2: v = 34'sd263043837;
         3: v = 34'sd133525159;
         4: v = 34'sd67021687;
         5: v = 34'sd33543516;
         6: v = 34'sd16775851;
         7: v = 34'sd8388437;
         8: v = 34'sd4194283;
         9: v = 34'sd2097149;
         default: v = (i > 30) ? '0 : (CORDIC_W'(1) <<< (30 - i));
      endcase
      return v;
   endfunction

endpackage

### hdl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine of half a Q3.13 angle, Q15 out.
// Depends on e2q_pkg. One register stage per iteration plus input and output stages.
module e2q_cordic #(
   parameter int STAGES = e2q_pkg::STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [e2q_pkg::ANGLE_W-1:0]   angle,
   output e2q_pkg::trig_type                    trig
);
   import e2q_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [STAGES+1];
   logic signed [CORDIC_W-1:0] y_ff [STAGES+1];
   logic signed [CORDIC_W-1:0] z_ff [STAGES+1];
   logic signed [ANGLE_W-1:0]  sat_in;
   logic signed [CORDIC_W-1:0] xr_in, yr_in;
   trig_type                   trig_ff;

   always_comb begin
      sat_in = angle;
      if (angle > ANGLE_LIMIT) sat_in = ANGLE_LIMIT;
      if (angle < -ANGLE_LIMIT) sat_in = -ANGLE_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= INV_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= CORDIC_W'(sat_in) <<< 16;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][CORDIC_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
         end
      end
   end

   assign xr_in = (x_ff[STAGES] + CORDIC_W'(16384)) >>> 15;
   assign yr_in = (y_ff[STAGES] + CORDIC_W'(16384)) >>> 15;

   always_ff @(posedge clock) begin
      if (advance) begin
         trig_ff.c <= xr_in[TRIG_W-1:0];
         trig_ff.s <= yr_in[TRIG_W-1:0];
      end
   end

   assign trig = trig_ff;
endmodule

### hdl/e2q_combine.sv
// Product stages: triple products of half-angle sines and cosines, sums, rounding to Q1.14.
// Depends on e2q_pkg. Three register stages.
module e2q_combine (
   input  logic              clock,
   input  logic              advance,
   input  e2q_pkg::trig_type roll,
   input  e2q_pkg::trig_type pitch,
   input  e2q_pkg::trig_type yaw,
   output e2q_pkg::rsp_type  quat
);
   import e2q_pkg::*;

   localparam int P2_W = 2 * TRIG_W;
   localparam int P3_W = 3 * TRIG_W;
   localparam int S_W  = P3_W + 1;

   logic signed [P2_W-1:0]   cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [TRIG_W-1:0] cy_ff, sy_ff;
   logic signed [P3_W-1:0]   p_ff [8];
   logic signed [S_W-1:0]    s_in [4];
   rsp_type                  quat_ff;

   function automatic logic signed [QUAT_W-1:0] to_q14(input logic signed [S_W-1:0] v);
      logic signed [S_W-1:0] r;
      r = (v + (S_W'(1) <<< 30)) >>> 31;
      if (r > S_W'(QUAT_LIMIT)) r = S_W'(QUAT_LIMIT);
      if (r < -S_W'(QUAT_LIMIT)) r = -S_W'(QUAT_LIMIT);
      return r[QUAT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         cc_ff <= P2_W'(roll.c) * P2_W'(pitch.c);
         ss_ff <= P2_W'(roll.s) * P2_W'(pitch.s);
         sc_ff <= P2_W'(roll.s) * P2_W'(pitch.c);
         cs_ff <= P2_W'(roll.c) * P2_W'(pitch.s);
         cy_ff <= yaw.c;
         sy_ff <= yaw.s;
         p_ff[0] <= P3_W'(cc_ff) * P3_W'(cy_ff);
         p_ff[1] <= P3_W'(ss_ff) * P3_W'(sy_ff);
         p_ff[2] <= P3_W'(sc_ff) * P3_W'(cy_ff);
         p_ff[3] <= P3_W'(cs_ff) * P3_W'(sy_ff);
         p_ff[4] <= P3_W'(cs_ff) * P3_W'(cy_ff);
         p_ff[5] <= P3_W'(sc_ff) * P3_W'(sy_ff);
         p_ff[6] <= P3_W'(cc_ff) * P3_W'(sy_ff);
         p_ff[7] <= P3_W'(ss_ff) * P3_W'(cy_ff);
         quat_ff.quat_w <= to_q14(s_in[0]);
         quat_ff.quat_x <= to_q14(s_in[1]);
         quat_ff.quat_y <= to_q14(s_in[2]);
         quat_ff.quat_z <= to_q14(s_in[3]);
      end
   end

   assign s_in[0] = S_W'(p_ff[0]) + S_W'(p_ff[1]);
   assign s_in[1] = S_W'(p_ff[2]) - S_W'(p_ff[3]);
   assign s_in[2] = S_W'(p_ff[4]) + S_W'(p_ff[5]);
   assign s_in[3] = S_W'(p_ff[6]) - S_W'(p_ff[7]);

   assign quat = quat_ff;
endmodule

### hdl/euler_to_quaternion.sv
// Top level of the ZYX Euler-angle to quaternion converter.
// Depends on e2q_pkg, e2q_cordic and e2q_combine.
//
//   channel   direction   payload
//   req_      in          roll, pitch, yaw angle (Q3.13)
//   rsp_      out         quat w, x, y, z (Q1.14)
//
// One request per cycle unless the output stalls; the latency is set by the CORDIC
// depth plus three product/sum stages and the input/rounding registers.
// Synchronous reset clears only the valid bits.
// A stall at the output freezes the whole pipeline, bubbles included, while the
// last stage holds a request; the input stalls in the same cycles.
module euler_to_quaternion #(
   parameter int STAGES = e2q_pkg::STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  e2q_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output e2q_pkg::rsp_type rsp_data
);
   import e2q_pkg::*;

   localparam int DEPTH = STAGES + 5;

   logic [DEPTH-1:0] valid_ff;
   logic             advance;
   trig_type         roll_t, pitch_t, yaw_t;

   assign advance   = !(valid_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   e2q_cordic #(.STAGES(STAGES)) u_roll (
      .clock(clock), .advance(advance), .angle(req_data.roll_angle), .trig(roll_t));
   e2q_cordic #(.STAGES(STAGES)) u_pitch (
      .clock(clock), .advance(advance), .angle(req_data.pitch_angle), .trig(pitch_t));
   e2q_cordic #(.STAGES(STAGES)) u_yaw (
      .clock(clock), .advance(advance), .angle(req_data.yaw_angle), .trig(yaw_t));

   e2q_combine u_combine (
      .clock(clock), .advance(advance), .roll(roll_t), .pitch(pitch_t), .yaw(yaw_t),
      .quat(rsp_data));

`ifndef SYNTH
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");
   a_range_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.quat_w <= QUAT_LIMIT && rsp_data.quat_w >= -QUAT_LIMIT)
      else $error("quat_w out of range");
`endif
endmodule
